// ===== rtl/stick_calibration_radius_table_assert.svh =====
// -----------------------------------------------------------------------------
// Stick calibration radius table assertion macros
// Concurrent assertion wrappers for the RTL; empty under synthesis.
// -----------------------------------------------------------------------------
`ifndef STICK_CALIBRATION_RADIUS_TABLE_ASSERT_SVH
`define STICK_CALIBRATION_RADIUS_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define SCR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCR_ASSERT(label, clk, rst_n, prop, msg)
`define SCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/scr_pkg.sv =====
// -----------------------------------------------------------------------------
// Stick calibration radius table package
// Widths, constants, codes and the arctangent step table.
// -----------------------------------------------------------------------------
package scr_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;

    localparam int RAD_W  = 15;
    localparam int ANG_W  = 16;
    localparam int CS_W   = 17;
    localparam int PT_W   = 18;
    localparam int MA_W   = 40;
    localparam int MB_W   = 18;
    localparam int PROD_W = 58;
    localparam int DIVN_W = 56;
    localparam int CRD_W  = 34;

    localparam logic [RAD_W-1:0]        RADIUS_MAX   = 15'h7fff;
    localparam logic signed [MA_W-1:0]  DOT_EPS      = 40'sd2684;
    localparam logic signed [MB_W-1:0]  POS_LO_SCALE = 18'sd100000;
    localparam logic signed [MB_W-1:0]  POS_HI_SCALE = 18'sd100001;
    localparam logic signed [CRD_W-1:0] CORDIC_START = 34'sd652032874;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_QUERY  = 2'd1,
        OP_WRITE  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_ENTRY,
        PH_RAY,
        PH_FIRST,
        PH_SECOND
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CRD_GO,
        S_CRD_WAIT,
        S_CHORD,
        S_ISECT,
        S_DIV_WAIT,
        S_DONE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    function automatic logic [13:0] atan_step(input logic [3:0] i);
        logic [13:0] v;
        case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/scr_cordic.sv =====
// -----------------------------------------------------------------------------
// Stick calibration CORDIC
// Iterative rotation, one step per cycle, giving Q2.14 cosine and sine.
// -----------------------------------------------------------------------------
module scr_cordic
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [scr_pkg::ANG_W-1:0]           angle,
    output scr_pkg::unit_status_t               status,
    output logic signed [scr_pkg::CS_W-1:0]     cos_val,
    output logic signed [scr_pkg::CS_W-1:0]     sin_val
);

    localparam int CW = scr_pkg::CRD_W;
    localparam int SW = scr_pkg::CS_W;
    localparam logic [CW-1:0] HALF = CW'(1) << 15;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [15:0]   z_reg, z_next;
    logic [3:0]           step_reg;
    logic [1:0]           quad_reg;
    logic                 busy_reg, done_reg;
    logic signed [CW-1:0] xs, ys, xa, ya;
    logic [CW-1:0]        xr, yr;
    logic signed [SW-1:0] cb, sb;

    always_comb
    begin
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        if (!z_reg[15])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - 16'(scr_pkg::atan_step(step_reg));
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + 16'(scr_pkg::atan_step(step_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 4'd15);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= scr_pkg::CORDIC_START;
            y_reg    <= '0;
            z_reg    <= signed'({2'b00, angle[13:0]});
            quad_reg <= angle[15:14];
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    always_comb
    begin
        xa = x_reg[CW-1] ? -x_reg : x_reg;
        ya = y_reg[CW-1] ? -y_reg : y_reg;
        xr = (unsigned'(xa) + HALF) >> 16;
        yr = (unsigned'(ya) + HALF) >> 16;
        cb = x_reg[CW-1] ? -signed'(SW'(xr)) : signed'(SW'(xr));
        sb = y_reg[CW-1] ? -signed'(SW'(yr)) : signed'(SW'(yr));
        case (quad_reg)
            2'd0:
            begin
                cos_val = cb;
                sin_val = sb;
            end
            2'd1:
            begin
                cos_val = -sb;
                sin_val = cb;
            end
            2'd2:
            begin
                cos_val = -cb;
                sin_val = -sb;
            end
            default:
            begin
                cos_val = sb;
                sin_val = -cb;
            end
        endcase
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/scr_mul.sv =====
// -----------------------------------------------------------------------------
// Stick calibration shared multiplier
// Signed multiplier with a registered product, shared by all products.
// -----------------------------------------------------------------------------
module scr_mul
(
    input  logic                                clk,
    input  logic signed [scr_pkg::MA_W-1:0]     a,
    input  logic signed [scr_pkg::MB_W-1:0]     b,
    output logic signed [scr_pkg::PROD_W-1:0]   prod
);

    logic signed [scr_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= scr_pkg::PROD_W'(a) * scr_pkg::PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/scr_div.sv =====
// -----------------------------------------------------------------------------
// Stick calibration divider
// Restoring divider, one quotient bit per cycle, saturating at the radius range.
// -----------------------------------------------------------------------------
module scr_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [scr_pkg::DIVN_W-1:0]          dividend,
    input  logic [scr_pkg::MA_W-1:0]            divisor,
    output scr_pkg::unit_status_t               status,
    output logic [scr_pkg::RAD_W-1:0]           quot
);

    localparam int DW = scr_pkg::DIVN_W;
    localparam int QW = scr_pkg::RAD_W;

    logic [DW-1:0] rem_reg, dvs_reg;
    logic [QW-1:0] q_reg;
    logic [3:0]    k_reg;
    logic          busy_reg, done_reg, sat_reg, ge;

    assign ge = (rem_reg >= dvs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (k_reg == 4'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= 4'd15;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg - 4'd1;
                if (k_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dvs_reg <= DW'(divisor) << 15;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvs_reg <= dvs_reg >> 1;
            if (k_reg == 4'd15)
            begin
                sat_reg <= ge;
            end
            else
            begin
                q_reg <= {q_reg[QW-2:0], ge};
                if (ge)
                begin
                    rem_reg <= rem_reg - dvs_reg;
                end
            end
        end
    end

    assign quot        = sat_reg ? scr_pkg::RADIUS_MAX : q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/stick_calibration_radius_table.sv =====
// -----------------------------------------------------------------------------
// Stick calibration radius table
// Radius per table angle, raised by stick segments, read back by angle query.
// -----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  opcode, segment, angle, entry
// output    out        out_valid/out_stall radius, used_fallback
//
// An update walks all table entries; each entry takes a CORDIC launch and run, the
// intersection multiplier steps, the 16-step divider when it runs, and the table update.
// A query takes three CORDIC runs, chord products, one intersection, the divider when
// it runs, and the output load. A write or an unused opcode leaves the block idle.
// Reset clears the table at once through per-entry valid bits.
// A query result waits in the output register while out_stall is high.
// -----------------------------------------------------------------------------
`include "stick_calibration_radius_table_assert.svh"

module stick_calibration_radius_table
#(
    parameter int TABLE_ENTRIES = scr_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          opcode,
    input  logic signed [15:0]                  seg_start_x,
    input  logic signed [15:0]                  seg_start_y,
    input  logic signed [15:0]                  seg_end_x,
    input  logic signed [15:0]                  seg_end_y,
    input  logic [15:0]                         query_angle,
    input  logic [4:0]                          entry_index,
    input  logic [14:0]                         entry_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [14:0]                         radius,
    output logic                                used_fallback
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int RW    = scr_pkg::RAD_W;
    localparam int PW    = scr_pkg::PT_W;
    localparam int AW    = scr_pkg::MA_W;
    localparam int BW    = scr_pkg::MB_W;
    localparam int XW    = scr_pkg::PROD_W;
    localparam int SW    = scr_pkg::CS_W;
    localparam int DW    = scr_pkg::DIVN_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [XW-1:0]    HALF14   = XW'(1) << 13;

    scr_pkg::state_t state_reg, state_next;
    scr_pkg::phase_t phase_reg;
    logic [3:0]              st_reg;
    logic [IDX_W-1:0]        idx_reg, i1_reg, i2_reg;
    logic [15:0]             qang_reg;
    logic signed [PW-1:0]    p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic signed [SW-1:0]    rc_reg, rs_reg;
    logic [RW-1:0]           r1_reg, dist_reg, rd_data_reg;
    logic signed [AW-1:0]    dot_reg, num_reg, cr_reg;
    logic signed [XW-1:0]    tlo_reg;
    logic                    fail_reg, pass_reg;
    logic                    out_valid_reg, out_fb_reg;
    logic [RW-1:0]           out_rad_reg;

    logic [RW-1:0]           mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [15:0]             ang_tab [TABLE_ENTRIES];

    logic                    accept, out_load, isect_fail, cr_pos;
    logic signed [PW-1:0]    dx, dy, chord_pt;
    logic [24:0]             qscale;
    logic [IDX_W-1:0]        qi1, wsel;
    logic [8:0]              wi;

    logic                    crd_start, rd_en, div_start, mem_we;
    logic [IDX_W-1:0]        ang_idx, rd_addr, mem_waddr;
    logic [RW-1:0]           mem_wdata;
    logic [15:0]             crd_angle;
    logic signed [AW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [XW-1:0]    prod;
    logic signed [SW-1:0]    crd_c, crd_s;
    scr_pkg::unit_status_t   crd_status, div_status;
    logic [RW-1:0]           div_q;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_ang
        assign ang_tab[g] = 16'((g * 65536) / TABLE_ENTRIES);
    end

    function automatic logic signed [PW-1:0] round14(input logic signed [XW-1:0] v);
        logic [XW-1:0] m;
        logic [PW-1:0] r;
        m = v[XW-1] ? unsigned'(-v) : unsigned'(v);
        r = PW'((m + HALF14) >> 14);
        return v[XW-1] ? -signed'(r) : signed'(r);
    endfunction

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != scr_pkg::S_IDLE);
    assign out_load = (state_reg == scr_pkg::S_OUT) && (!out_valid_reg || !out_stall);
    assign dx       = p2x_reg - p1x_reg;
    assign dy       = p2y_reg - p1y_reg;
    assign qscale   = 25'(query_angle) * 25'(TABLE_ENTRIES);
    assign qi1      = qscale[16 +: IDX_W];
    assign wi       = 9'(entry_index);
    assign wsel     = wi[IDX_W-1:0];
    assign chord_pt = round14(prod);
    assign isect_fail = fail_reg || (tlo_reg > prod);
    assign cr_pos   = (cr_reg > 0);

    scr_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (crd_start),
        .angle   (crd_angle),
        .status  (crd_status),
        .cos_val (crd_c),
        .sin_val (crd_s)
    );

    scr_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    scr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ((DW'(unsigned'(cr_reg)) << 14) + DW'(unsigned'(dot_reg) >> 1)),
        .divisor  (unsigned'(dot_reg)),
        .status   (div_status),
        .quot     (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scr_pkg::S_IDLE:
            begin
                if (accept && (opcode == scr_pkg::OP_UPDATE || opcode == scr_pkg::OP_QUERY))
                begin
                    state_next = scr_pkg::S_CRD_GO;
                end
            end
            scr_pkg::S_CRD_GO:
            begin
                state_next = scr_pkg::S_CRD_WAIT;
            end
            scr_pkg::S_CRD_WAIT:
            begin
                if (crd_status.done)
                begin
                    unique case (phase_reg)
                        scr_pkg::PH_ENTRY: state_next = scr_pkg::S_ISECT;
                        scr_pkg::PH_RAY:   state_next = scr_pkg::S_CRD_GO;
                        default:           state_next = scr_pkg::S_CHORD;
                    endcase
                end
            end
            scr_pkg::S_CHORD:
            begin
                if (st_reg == 4'd2)
                begin
                    state_next = (phase_reg == scr_pkg::PH_FIRST) ? scr_pkg::S_CRD_GO
                                                                  : scr_pkg::S_ISECT;
                end
            end
            scr_pkg::S_ISECT:
            begin
                if (st_reg == 4'd10)
                begin
                    state_next = (!isect_fail && cr_pos) ? scr_pkg::S_DIV_WAIT
                                                         : scr_pkg::S_DONE;
                end
            end
            scr_pkg::S_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = scr_pkg::S_DONE;
                end
            end
            scr_pkg::S_DONE:
            begin
                if (phase_reg != scr_pkg::PH_ENTRY)
                begin
                    state_next = scr_pkg::S_OUT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = scr_pkg::S_IDLE;
                end
                else
                begin
                    state_next = scr_pkg::S_CRD_GO;
                end
            end
            scr_pkg::S_OUT:
            begin
                if (out_load)
                begin
                    state_next = scr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = scr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        crd_start = (state_reg == scr_pkg::S_CRD_GO);
        rd_en     = (state_reg == scr_pkg::S_CRD_GO);
        div_start = (state_reg == scr_pkg::S_ISECT) && (st_reg == 4'd10)
                    && !isect_fail && cr_pos;
        unique case (phase_reg)
            scr_pkg::PH_ENTRY: ang_idx = idx_reg;
            scr_pkg::PH_FIRST: ang_idx = i1_reg;
            default:           ang_idx = i2_reg;
        endcase
        rd_addr   = ang_idx;
        crd_angle = (phase_reg == scr_pkg::PH_RAY) ? qang_reg : ang_tab[ang_idx];
        mem_we    = 1'b0;
        mem_waddr = wsel;
        mem_wdata = entry_value;
        if (state_reg == scr_pkg::S_IDLE)
        begin
            mem_we = accept && (opcode == scr_pkg::OP_WRITE)
                     && (32'(entry_index) < TABLE_ENTRIES);
        end
        else if (state_reg == scr_pkg::S_DONE && phase_reg == scr_pkg::PH_ENTRY)
        begin
            mem_we    = pass_reg && (dist_reg > rd_data_reg);
            mem_waddr = idx_reg;
            mem_wdata = dist_reg;
        end
        mul_a = AW'(rc_reg);
        mul_b = dy;
        if (state_reg == scr_pkg::S_CHORD)
        begin
            mul_a = (st_reg == 4'd0) ? AW'(crd_c) : AW'(crd_s);
            mul_b = signed'(BW'(rd_data_reg));
        end
        else
        begin
            case (st_reg)
                4'd1:
                begin
                    mul_a = AW'(rs_reg);
                    mul_b = dx;
                end
                4'd2:
                begin
                    mul_a = AW'(rs_reg);
                    mul_b = p1x_reg;
                end
                4'd3:
                begin
                    mul_a = AW'(rc_reg);
                    mul_b = p1y_reg;
                end
                4'd4:
                begin
                    mul_a = AW'(p1x_reg);
                    mul_b = dy;
                end
                4'd5:
                begin
                    mul_a = AW'(p1y_reg);
                    mul_b = dx;
                end
                4'd8:
                begin
                    mul_a = num_reg;
                    mul_b = scr_pkg::POS_LO_SCALE;
                end
                4'd9:
                begin
                    mul_a = dot_reg;
                    mul_b = scr_pkg::POS_HI_SCALE;
                end
                default:
                begin
                    mul_a = AW'(rc_reg);
                    mul_b = dy;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scr_pkg::S_IDLE;
            phase_reg     <= scr_pkg::PH_ENTRY;
            st_reg        <= '0;
            idx_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_next != state_reg)
            begin
                st_reg <= '0;
            end
            else
            begin
                st_reg <= st_reg + 4'd1;
            end
            if (accept)
            begin
                idx_reg   <= '0;
                phase_reg <= (opcode == scr_pkg::OP_QUERY) ? scr_pkg::PH_RAY
                                                           : scr_pkg::PH_ENTRY;
            end
            else if (state_reg == scr_pkg::S_CRD_WAIT && crd_status.done
                     && phase_reg == scr_pkg::PH_RAY)
            begin
                phase_reg <= scr_pkg::PH_FIRST;
            end
            else if (state_reg == scr_pkg::S_CHORD && st_reg == 4'd2
                     && phase_reg == scr_pkg::PH_FIRST)
            begin
                phase_reg <= scr_pkg::PH_SECOND;
            end
            else if (state_reg == scr_pkg::S_DONE && phase_reg == scr_pkg::PH_ENTRY)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1x_reg  <= PW'(seg_start_x);
            p1y_reg  <= PW'(seg_start_y);
            p2x_reg  <= PW'(seg_end_x);
            p2y_reg  <= PW'(seg_end_y);
            qang_reg <= query_angle;
            i1_reg   <= qi1;
            i2_reg   <= (qi1 == LAST_IDX) ? '0 : qi1 + IDX_W'(1);
        end
        if (state_reg == scr_pkg::S_CRD_WAIT && crd_status.done
            && (phase_reg == scr_pkg::PH_RAY || phase_reg == scr_pkg::PH_ENTRY))
        begin
            rc_reg <= crd_c;
            rs_reg <= crd_s;
        end
        if (state_reg == scr_pkg::S_CHORD)
        begin
            if (phase_reg == scr_pkg::PH_FIRST)
            begin
                if (st_reg == 4'd1)
                begin
                    p1x_reg <= chord_pt;
                end
                if (st_reg == 4'd2)
                begin
                    p1y_reg <= chord_pt;
                    r1_reg  <= rd_data_reg;
                end
            end
            else
            begin
                if (st_reg == 4'd1)
                begin
                    p2x_reg <= chord_pt;
                end
                if (st_reg == 4'd2)
                begin
                    p2y_reg <= chord_pt;
                end
            end
        end
        if (state_reg == scr_pkg::S_ISECT)
        begin
            case (st_reg)
                4'd1: dot_reg <= AW'(prod);
                4'd2: dot_reg <= dot_reg - AW'(prod);
                4'd3: num_reg <= AW'(prod);
                4'd4: num_reg <= num_reg - AW'(prod);
                4'd5: cr_reg  <= AW'(prod);
                4'd6: cr_reg  <= cr_reg - AW'(prod);
                4'd7:
                begin
                    if (dot_reg < 0)
                    begin
                        dot_reg <= -dot_reg;
                        num_reg <= -num_reg;
                        cr_reg  <= -cr_reg;
                    end
                end
                4'd8: fail_reg <= (dot_reg <= scr_pkg::DOT_EPS);
                4'd9:
                begin
                    tlo_reg  <= prod;
                    fail_reg <= fail_reg || (prod < -XW'(dot_reg));
                end
                4'd10:
                begin
                    pass_reg <= !isect_fail;
                    dist_reg <= '0;
                end
                default:
                begin
                    pass_reg <= pass_reg;
                end
            endcase
        end
        if (state_reg == scr_pkg::S_DIV_WAIT && div_status.done)
        begin
            dist_reg <= div_q;
        end
        if (out_load)
        begin
            out_rad_reg <= pass_reg ? dist_reg : r1_reg;
            out_fb_reg  <= !pass_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign radius        = out_rad_reg;
    assign used_fallback = out_fb_reg;

    `SCR_ASSERT(a_crd_start_free, clk, rst_n, crd_start |-> !crd_status.busy, "CORDIC restarted while busy")
    `SCR_ASSERT_NEXT(a_div_to_done, clk, rst_n, div_status.done, state_reg == scr_pkg::S_DONE, "divider result not taken")
    `SCR_ASSERT(a_mem_we_state, clk, rst_n, mem_we |-> (state_reg == scr_pkg::S_IDLE || state_reg == scr_pkg::S_DONE), "table written outside a write or update step")

endmodule
